// ----- hdl/fpsa_pkg.sv -----
`default_nettype none

package fpsa_pkg;

	localparam int DEF_SLOTS = 80;
	localparam int POLICIES  = 4;

	localparam int IN_W  = 24;
	localparam int OUT_W = 16;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic [1:0] POL_FIRST = 2'd0;
	localparam logic [1:0] POL_NEXT  = 2'd1;
	localparam logic [1:0] POL_BEST  = 2'd2;
	localparam logic [1:0] POL_WORST = 2'd3;

	localparam logic [1:0] ST_PLACED  = 2'd0;
	localparam logic [1:0] ST_NOSPACE = 2'd1;
	localparam logic [1:0] ST_FREED   = 2'd2;
	localparam logic [1:0] ST_BADLEN  = 2'd3;

	typedef struct packed {
		logic capture;
		logic load;
		logic clear;
		logic rew_step;
		logic scan_init;
		logic scan_step;
		logic scan_pass2;
		logic mark;
		logic nospace;
		logic badlen;
		logic write;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic len_zero;
		logic is_free;
		logic is_next;
		logic len_big;
		logic rew_done;
		logic hit;
		logic last;
		logic pass2;
		logic rov_nz;
		logic found;
	} stat_t;

endpackage

`default_nettype wire

// ----- hdl/fpsa_ram.sv -----
`default_nettype none

module fpsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- hdl/fpsa_ctrl.sv -----
`default_nettype none

module fpsa_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output      logic          s_tready,
	output      logic          m_tvalid,
	input  wire logic          m_tready,
	input  wire fpsa_pkg::stat_t st,
	output      fpsa_pkg::cmd_t  cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_LOAD   = 3'd1;
	localparam logic [2:0] S_DECIDE = 3'd2;
	localparam logic [2:0] S_REWIND = 3'd3;
	localparam logic [2:0] S_SCAN   = 3'd4;
	localparam logic [2:0] S_CHECK  = 3'd5;
	localparam logic [2:0] S_WB     = 3'd6;
	localparam logic [2:0] S_DONE   = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_nx;
	logic       out_valid_q;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_nx    = S_LOAD;
				end
			end
			S_LOAD: begin
				cmd.load = 1'b1;
				state_nx = S_DECIDE;
			end
			S_DECIDE: begin
				if (st.len_zero) begin
					cmd.badlen = 1'b1;
					state_nx   = S_DONE;
				end else if (st.is_free) begin
					cmd.clear = 1'b1;
					state_nx  = S_WB;
				end else if (st.is_next) begin
					state_nx = S_REWIND;
				end else if (st.len_big) begin
					cmd.nospace = 1'b1;
					state_nx    = S_DONE;
				end else begin
					cmd.scan_init = 1'b1;
					state_nx      = S_SCAN;
				end
			end
			S_REWIND: begin
				if (!st.rew_done) begin
					cmd.rew_step = 1'b1;
				end else if (st.len_big) begin
					cmd.nospace = 1'b1;
					state_nx    = S_DONE;
				end else begin
					cmd.scan_init = 1'b1;
					state_nx      = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (st.hit) begin
					state_nx = S_CHECK;
				end else if (st.last) begin
					if (st.is_next && !st.pass2 && st.rov_nz) begin
						cmd.scan_pass2 = 1'b1;
					end else begin
						state_nx = S_CHECK;
					end
				end
			end
			S_CHECK: begin
				if (st.found) begin
					cmd.mark = 1'b1;
					state_nx = S_WB;
				end else begin
					cmd.nospace = 1'b1;
					state_nx    = S_DONE;
				end
			end
			S_WB: begin
				cmd.write = 1'b1;
				state_nx  = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ----- hdl/fpsa_dp.sv -----
`default_nettype none

module fpsa_dp #(
	parameter int SLOTS = fpsa_pkg::DEF_SLOTS
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [fpsa_pkg::IN_W-1:0]  s_tdata,
	input  wire fpsa_pkg::cmd_t             cmd,
	output      fpsa_pkg::stat_t            st,
	output      logic                       ram_re,
	output      logic [1:0]                 ram_raddr,
	input  wire logic [SLOTS-1:0]           ram_rdata,
	output      logic                       ram_we,
	output      logic [1:0]                 ram_waddr,
	output      logic [SLOTS-1:0]           ram_wdata,
	output      logic [fpsa_pkg::OUT_W-1:0] m_tdata
);

	localparam int IW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);
	localparam int LW = (CW > 7) ? CW : 7;
	localparam int MW = LW + 1;

	logic                         cmd_q;
	logic [1:0]                   policy_q;
	logic [6:0]                   len_q;
	logic [6:0]                   start_q;
	logic [SLOTS-1:0]             map_q;
	logic [fpsa_pkg::POLICIES-1:0] valid_q;
	logic [IW-1:0]                rover_q;
	logic [IW-1:0]                i_q;
	logic [CW-1:0]                hi_q;
	logic [CW-1:0]                cnt_q;
	logic [IW-1:0]                rs_q;
	logic [IW-1:0]                pick_q;
	logic [CW-1:0]                plen_q;
	logic                         found_q;
	logic                         pass2_q;
	logic [1:0]                   res_status_q;
	logic [6:0]                   res_slot_q;
	logic [fpsa_pkg::OUT_W-1:0]   m_tdata_q;

	logic [LW-1:0]    len_w;
	logic             cur_free;
	logic [IW-1:0]    rov_m1;
	logic             window;
	logic [CW-1:0]    cnt_nx;
	logic             hit;
	logic             last;
	logic [IW-1:0]    win_p;
	logic [IW-1:0]    cand_start;
	logic [CW-1:0]    cand_len;
	logic             cand_evt;
	logic             better;
	logic             cand_take;
	logic [SLOTS-1:0] set_m;
	logic [SLOTS-1:0] clr_m;
	logic [IW+6:0]    pick_ext;

	assign len_w    = LW'(len_q);
	assign cur_free = ~map_q[i_q];
	assign rov_m1   = rover_q - 1'b1;
	assign window   = (policy_q == fpsa_pkg::POL_FIRST) || (policy_q == fpsa_pkg::POL_NEXT);
	assign cnt_nx   = cur_free ? cnt_q + 1'b1 : '0;
	assign hit      = window && cur_free && (LW'(cnt_nx) == len_w);
	assign last     = ((CW'(i_q) + CW'(1)) == hi_q);
	assign win_p    = IW'(LW'(i_q) + LW'(1) - len_w);

	assign cand_start = (cur_free && (cnt_q == '0)) ? i_q : rs_q;
	assign cand_len   = cur_free ? cnt_nx : cnt_q;
	assign cand_evt   = !window && (cur_free ? last : (cnt_q != '0));
	assign better     = !found_q ||
		((policy_q == fpsa_pkg::POL_WORST) ? (cand_len > plen_q) : (cand_len < plen_q));
	assign cand_take  = cand_evt && (LW'(cand_len) >= len_w) && better;

	always_comb begin
		for (int k = 0; k < SLOTS; k++) begin
			set_m[k] = (MW'(k) >= MW'(pick_q)) && (MW'(k) < MW'(pick_q) + MW'(len_q));
			clr_m[k] = (MW'(k) >= MW'(start_q)) && (MW'(k) < MW'(start_q) + MW'(len_q));
		end
	end

	assign pick_ext = (IW + 7)'(pick_q);

	assign st.len_zero = (len_q == 7'd0);
	assign st.is_free  = (cmd_q == fpsa_pkg::CMD_FREE);
	assign st.is_next  = (policy_q == fpsa_pkg::POL_NEXT);
	assign st.len_big  = (len_w > LW'(SLOTS));
	assign st.rew_done = map_q[rover_q] || (rover_q == '0) || map_q[rov_m1];
	assign st.hit      = hit;
	assign st.last     = last;
	assign st.pass2    = pass2_q;
	assign st.rov_nz   = (rover_q != '0);
	assign st.found    = found_q;

	assign ram_re    = cmd.capture;
	assign ram_raddr = s_tdata[2:1];
	assign ram_we    = cmd.write;
	assign ram_waddr = policy_q;
	assign ram_wdata = map_q;
	assign m_tdata   = m_tdata_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q    <= s_tdata[0];
			policy_q <= s_tdata[2:1];
			len_q    <= s_tdata[9:3];
			start_q  <= s_tdata[16:10];
		end

		if (cmd.load) begin
			map_q <= valid_q[policy_q] ? ram_rdata : '0;
		end else if (cmd.clear) begin
			map_q <= map_q & ~clr_m;
		end else if (cmd.mark) begin
			map_q <= map_q | set_m;
		end

		if (cmd.scan_init) begin
			i_q     <= st.is_next ? rover_q : '0;
			hi_q    <= CW'(SLOTS);
			cnt_q   <= '0;
			found_q <= 1'b0;
			pass2_q <= 1'b0;
		end else if (cmd.scan_pass2) begin
			i_q     <= '0;
			hi_q    <= CW'(rover_q);
			cnt_q   <= '0;
			pass2_q <= 1'b1;
		end else if (cmd.scan_step) begin
			i_q   <= i_q + 1'b1;
			cnt_q <= cnt_nx;
			if (cur_free && (cnt_q == '0)) begin
				rs_q <= i_q;
			end
			if (hit) begin
				found_q <= 1'b1;
				pick_q  <= win_p;
			end
			if (cand_take) begin
				found_q <= 1'b1;
				pick_q  <= cand_start;
				plen_q  <= cand_len;
			end
		end

		if (cmd.clear) begin
			res_status_q <= fpsa_pkg::ST_FREED;
			res_slot_q   <= 7'd0;
		end else if (cmd.mark) begin
			res_status_q <= fpsa_pkg::ST_PLACED;
			res_slot_q   <= pick_ext[6:0];
		end else if (cmd.nospace) begin
			res_status_q <= fpsa_pkg::ST_NOSPACE;
			res_slot_q   <= 7'd0;
		end else if (cmd.badlen) begin
			res_status_q <= fpsa_pkg::ST_BADLEN;
			res_slot_q   <= 7'd0;
		end

		if (cmd.out_load) begin
			m_tdata_q <= fpsa_pkg::OUT_W'({res_slot_q, res_status_q});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rover_q <= '0;
		end else begin
			if (cmd.rew_step) begin
				rover_q <= rov_m1;
			end else if (cmd.mark && st.is_next) begin
				rover_q <= pick_q;
			end
			if (cmd.write) begin
				valid_q[policy_q] <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- hdl/fit_policy_slot_allocator.sv -----
// one request at a time, one result beat per request, the next request is taken as soon as
// the result appears; for an allocation the time is set by the one-slot-per-cycle scan of
// the map (next fit: rewind walk plus both passes), then a mark or clear step and a write-back
// step; a stalled result beat adds its stall
// a new request is taken while the previous result still waits in the output register
// reset: all maps read as free through per-policy valid flags, rover zero, no clearing pass
`default_nettype none

module fit_policy_slot_allocator #(
	parameter int SLOTS = fpsa_pkg::DEF_SLOTS
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_tvalid,
	output      logic                       s_tready,
	// cmd, policy, run_length, start_slot
	input  wire logic [fpsa_pkg::IN_W-1:0]  s_tdata,
	output      logic                       m_tvalid,
	input  wire logic                       m_tready,
	// status, placed_slot
	output      logic [fpsa_pkg::OUT_W-1:0] m_tdata
);

	fpsa_pkg::cmd_t  cmd;
	fpsa_pkg::stat_t st;

	logic             ram_re;
	logic [1:0]       ram_raddr;
	logic [SLOTS-1:0] ram_rdata;
	logic             ram_we;
	logic [1:0]       ram_waddr;
	logic [SLOTS-1:0] ram_wdata;

	fpsa_ram #(
		.WIDTH(SLOTS),
		.DEPTH(fpsa_pkg::POLICIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	fpsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.st       (st),
		.cmd      (cmd)
	);

	fpsa_dp #(
		.SLOTS(SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.cmd       (cmd),
		.st        (st),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.m_tdata   (m_tdata)
	);

endmodule

`default_nettype wire
